FILE: hw/rtl/elss_pkg.sv
package elss_pkg;

  localparam int unsigned UNIT_RATE_SHIFT = 16;
  localparam int unsigned DIV_STEPS = 64;

  typedef enum logic [1:0] {
    MODE_EDIT   = 2'd0,
    MODE_SAMPLE = 2'd1,
    MODE_SEEK   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NONE       = 3'd1,
    ST_ZERO_SCALE = 3'd2,
    ST_NEG_EDIT   = 3'd3,
    ST_REVERSE    = 3'd4,
    ST_OVERFLOW   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    REG_TIMESCALE    = 2'd0,
    REG_EDIT_COUNT   = 2'd1,
    REG_SAMPLE_COUNT = 2'd2,
    REG_UNUSED       = 2'd3
  } reg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_WALK,
    S_SCALE_INIT,
    S_GCD,
    S_GWAIT,
    S_FWAIT,
    S_DWAIT,
    S_MULNEXT,
    S_MUL,
    S_OFF,
    S_OWAIT,
    S_SINIT,
    S_SRCH,
    S_SCMP,
    S_FCMP,
    S_RESULT
  } state_t;

endpackage

FILE: hw/rtl/elss_if.sv
interface elss_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [11:0] entry_index;
  logic [63:0] edit_span;
  logic signed [63:0] edit_start;
  logic signed [31:0] edit_speed;
  logic [63:0] sample_start;
  logic [31:0] sample_length;
  logic [63:0] query_time;
  logic [31:0] query_scale;

  modport source (output valid, mode, entry_index, edit_span, edit_start, edit_speed,
                  sample_start, sample_length, query_time, query_scale, input ready);
  modport sink (input valid, mode, entry_index, edit_span, edit_start, edit_speed,
                sample_start, sample_length, query_time, query_scale, output ready);
endinterface

interface elss_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [11:0] found_index;

  modport source (output valid, status, found_index, input ready);
  modport sink (input valid, status, found_index, output ready);
endinterface

FILE: hw/rtl/edit_list_sample_seek.sv
// Load items: the result transfer is offered on the next cycle after the item is taken.
// Seek: each Euclid step, each exact division and the final offset division use the
// shared restoring divider, the three products are formed one after another, and every
// binary-search probe reads the sample table and then compares.
// One item at a time; input ready only when idle and the output register is free.
// Synchronous active-high reset clears control and the configuration registers; tables are not cleared.
module edit_list_sample_seek #(
  parameter int EDIT_DEPTH   = 16,
  parameter int SAMPLE_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  elss_in_if.sink     in_ch,
  elss_out_if.source  out_ch
);

  localparam int EW  = $clog2(EDIT_DEPTH + 1);
  localparam int EIW = (EDIT_DEPTH > 1) ? $clog2(EDIT_DEPTH) : 1;
  localparam int SW  = $clog2(SAMPLE_DEPTH + 1);
  localparam int SIW = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;

  logic [31:0] track_timescale;
  logic [4:0]  edit_count;
  logic [12:0] sample_total;

  logic [63:0] edit_span_tab  [EDIT_DEPTH];
  logic [63:0] edit_start_tab [EDIT_DEPTH];
  logic [31:0] edit_speed_tab [EDIT_DEPTH];
  logic [63:0] sample_start_mem  [SAMPLE_DEPTH];
  logic [31:0] sample_length_mem [SAMPLE_DEPTH];

  elss_pkg::state_t state, state_next;

  logic [63:0] elapsed, origin, media, den, ga, gb, num;
  logic [31:0] qscale, rate;
  logic [63:0] fac [3];
  logic [1:0]  fi, mi;
  logic [EW-1:0] ei, n_edit;
  logic [SW-1:0] lo, hi, mid, n_samp, mid_calc;
  elss_pkg::status_t res_status;
  logic [11:0] res_index;

  logic        ovalid;
  logic [2:0]  ostatus;
  logic [11:0] oindex;

  logic        div_start;
  logic [63:0] div_a, div_b, dq, dr, dd;
  logic [6:0]  dcnt;
  logic [64:0] div_rr;
  logic        div_ge;

  logic [128:0] mp;
  logic [6:0]   mcnt;
  logic [64:0]  mul_sum;

  logic [SIW-1:0] rd_addr;
  logic [63:0] rd_start;
  logic [31:0] rd_len;
  logic [64:0] media_sum;
  logic [63:0] media_diff;

  logic [EIW-1:0] eidx;
  logic [63:0] sel_span, sel_start;
  logic [31:0] sel_speed;
  logic        in_xfer, out_free, cfg_wr;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign out_free = !ovalid || out_ch.ready;
  assign in_xfer  = in_ch.valid && in_ch.ready;

  assign n_edit = (32'(edit_count) > EDIT_DEPTH) ? EW'(EDIT_DEPTH) : EW'(edit_count);
  assign n_samp = (32'(sample_total) > SAMPLE_DEPTH) ? SW'(SAMPLE_DEPTH) : SW'(sample_total);

  assign eidx      = EIW'(ei);
  assign sel_span  = edit_span_tab[eidx];
  assign sel_start = edit_start_tab[eidx];
  assign sel_speed = edit_speed_tab[eidx];

  assign mid_calc   = lo + ((hi - lo) >> 1);
  assign div_rr     = {dr, dq[63]};
  assign div_ge     = div_rr >= {1'b0, dd};
  assign mul_sum    = {1'b0, mp[127:64]} + (mp[0] ? {1'b0, num} : 65'd0);
  assign media_sum  = {1'b0, origin} + {1'b0, dq};
  assign media_diff = media - rd_start;

  always_comb begin
    case (elss_pkg::reg_idx_t'(paddr[3:2]))
      elss_pkg::REG_TIMESCALE:    prdata = track_timescale;
      elss_pkg::REG_EDIT_COUNT:   prdata = 32'(edit_count);
      elss_pkg::REG_SAMPLE_COUNT: prdata = 32'(sample_total);
      default:                    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      track_timescale <= 32'd1;
      edit_count      <= 5'd0;
      sample_total    <= 13'd0;
    end else if (cfg_wr) begin
      case (elss_pkg::reg_idx_t'(paddr[3:2]))
        elss_pkg::REG_TIMESCALE:    track_timescale <= pwdata;
        elss_pkg::REG_EDIT_COUNT:   edit_count <= pwdata[4:0];
        elss_pkg::REG_SAMPLE_COUNT: sample_total <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      elss_pkg::S_IDLE:
        if (in_xfer && elss_pkg::mode_t'(in_ch.mode) == elss_pkg::MODE_SEEK)
          state_next = elss_pkg::S_CHECK;
      elss_pkg::S_CHECK:
        if (qscale == 32'd0 || track_timescale == 32'd0) state_next = elss_pkg::S_RESULT;
        else if (n_edit == '0) state_next = elss_pkg::S_SCALE_INIT;
        else state_next = elss_pkg::S_WALK;
      elss_pkg::S_WALK:
        if (ei == n_edit) state_next = elss_pkg::S_RESULT;
        else if (elapsed < sel_span) begin
          if (sel_start[63] || sel_speed[31]) state_next = elss_pkg::S_RESULT;
          else if (sel_speed == 32'd0) state_next = elss_pkg::S_SINIT;
          else state_next = elss_pkg::S_SCALE_INIT;
        end
      elss_pkg::S_SCALE_INIT: state_next = elss_pkg::S_GCD;
      elss_pkg::S_GCD:
        state_next = (gb == 64'd0) ? elss_pkg::S_FWAIT : elss_pkg::S_GWAIT;
      elss_pkg::S_GWAIT:
        if (dcnt == 7'd0) state_next = elss_pkg::S_GCD;
      elss_pkg::S_FWAIT:
        if (dcnt == 7'd0) state_next = elss_pkg::S_DWAIT;
      elss_pkg::S_DWAIT:
        if (dcnt == 7'd0) state_next = (fi == 2'd2) ? elss_pkg::S_MULNEXT : elss_pkg::S_GCD;
      elss_pkg::S_MULNEXT:
        state_next = (mi == 2'd3) ? elss_pkg::S_OFF : elss_pkg::S_MUL;
      elss_pkg::S_MUL:
        if (mcnt == 7'd0)
          state_next = (mp[127:64] != 64'd0) ? elss_pkg::S_RESULT : elss_pkg::S_MULNEXT;
      elss_pkg::S_OFF: state_next = elss_pkg::S_OWAIT;
      elss_pkg::S_OWAIT:
        if (dcnt == 7'd0) state_next = media_sum[64] ? elss_pkg::S_RESULT : elss_pkg::S_SINIT;
      elss_pkg::S_SINIT: state_next = elss_pkg::S_SRCH;
      elss_pkg::S_SRCH:
        if (lo < hi) state_next = elss_pkg::S_SCMP;
        else if (lo == '0) state_next = elss_pkg::S_RESULT;
        else state_next = elss_pkg::S_FCMP;
      elss_pkg::S_SCMP: state_next = elss_pkg::S_SRCH;
      elss_pkg::S_FCMP: state_next = elss_pkg::S_RESULT;
      elss_pkg::S_RESULT:
        if (out_free) state_next = elss_pkg::S_IDLE;
      default: state_next = elss_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    div_start   = 1'b0;
    div_a       = 64'd0;
    div_b       = 64'd1;
    rd_addr     = '0;
    case (state)
      elss_pkg::S_IDLE: in_ch.ready = out_free;
      elss_pkg::S_GCD: begin
        div_start = 1'b1;
        if (gb == 64'd0) begin
          div_a = fac[fi];
          div_b = ga;
        end else begin
          div_a = ga;
          div_b = gb;
        end
      end
      elss_pkg::S_FWAIT: begin
        div_start = (dcnt == 7'd0);
        div_a     = den;
        div_b     = ga;
      end
      elss_pkg::S_OFF: begin
        div_start = 1'b1;
        div_a     = num;
        div_b     = den;
      end
      elss_pkg::S_SRCH: rd_addr = (lo < hi) ? SIW'(mid_calc) : SIW'(lo - 1'b1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= elss_pkg::S_IDLE;
      dcnt  <= 7'd0;
      mcnt  <= 7'd0;
    end else begin
      state <= state_next;
      if (div_start) dcnt <= 7'(elss_pkg::DIV_STEPS);
      else if (dcnt != 7'd0) dcnt <= dcnt - 7'd1;
      if (state == elss_pkg::S_MULNEXT && mi != 2'd3) mcnt <= 7'd64;
      else if (mcnt != 7'd0) mcnt <= mcnt - 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      dq <= div_a;
      dd <= div_b;
      dr <= 64'd0;
    end else if (dcnt != 7'd0) begin
      dq <= {dq[62:0], div_ge};
      dr <= div_ge ? 64'(div_rr - {1'b0, dd}) : div_rr[63:0];
    end
    if (state == elss_pkg::S_MULNEXT && mi != 2'd3) mp <= {65'd0, fac[mi]};
    else if (mcnt != 7'd0) mp <= {1'b0, mul_sum, mp[63:1]};
  end

  always_ff @(posedge clk) begin
    rd_start <= sample_start_mem[rd_addr];
    rd_len   <= sample_length_mem[rd_addr];
    if (in_xfer && elss_pkg::mode_t'(in_ch.mode) == elss_pkg::MODE_SAMPLE
        && 32'(in_ch.entry_index) < SAMPLE_DEPTH) begin
      sample_start_mem[SIW'(in_ch.entry_index)]  <= in_ch.sample_start;
      sample_length_mem[SIW'(in_ch.entry_index)] <= in_ch.sample_length;
    end
    if (in_xfer && elss_pkg::mode_t'(in_ch.mode) == elss_pkg::MODE_EDIT
        && 32'(in_ch.entry_index) < EDIT_DEPTH) begin
      edit_span_tab[EIW'(in_ch.entry_index)]  <= in_ch.edit_span;
      edit_start_tab[EIW'(in_ch.entry_index)] <= in_ch.edit_start;
      edit_speed_tab[EIW'(in_ch.entry_index)] <= in_ch.edit_speed;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      elss_pkg::S_IDLE: begin
        elapsed    <= in_ch.query_time;
        qscale     <= in_ch.query_scale;
        origin     <= 64'd0;
        rate       <= 32'd1 << elss_pkg::UNIT_RATE_SHIFT;
        ei         <= '0;
        res_status <= elss_pkg::ST_OK;
        res_index  <= 12'd0;
      end
      elss_pkg::S_CHECK:
        if (qscale == 32'd0 || track_timescale == 32'd0) res_status <= elss_pkg::ST_ZERO_SCALE;
      elss_pkg::S_WALK:
        if (ei == n_edit) res_status <= elss_pkg::ST_NONE;
        else if (elapsed < sel_span) begin
          rate   <= sel_speed;
          origin <= sel_start;
          media  <= sel_start;
          if (sel_start == 64'hFFFF_FFFF_FFFF_FFFF) res_status <= elss_pkg::ST_NONE;
          else if (sel_start[63]) res_status <= elss_pkg::ST_NEG_EDIT;
          else if (sel_speed[31]) res_status <= elss_pkg::ST_REVERSE;
        end else begin
          elapsed <= elapsed - sel_span;
          ei      <= ei + 1'b1;
        end
      elss_pkg::S_SCALE_INIT: begin
        den    <= {16'd0, qscale, 16'd0};
        fac[0] <= elapsed;
        fac[1] <= 64'(track_timescale);
        fac[2] <= 64'(rate);
        fi     <= 2'd0;
        ga     <= elapsed;
        gb     <= {16'd0, qscale, 16'd0};
      end
      elss_pkg::S_GWAIT:
        if (dcnt == 7'd0) begin
          ga <= gb;
          gb <= dr;
        end
      elss_pkg::S_FWAIT:
        if (dcnt == 7'd0) fac[fi] <= dq;
      elss_pkg::S_DWAIT:
        if (dcnt == 7'd0) begin
          den <= dq;
          if (fi == 2'd2) begin
            num <= 64'd1;
            mi  <= 2'd0;
          end else begin
            fi <= fi + 2'd1;
            ga <= fac[fi + 2'd1];
            gb <= dq;
          end
        end
      elss_pkg::S_MUL:
        if (mcnt == 7'd0) begin
          if (mp[127:64] != 64'd0) res_status <= elss_pkg::ST_OVERFLOW;
          else begin
            num <= mp[63:0];
            mi  <= mi + 2'd1;
          end
        end
      elss_pkg::S_OWAIT:
        if (dcnt == 7'd0) begin
          media <= media_sum[63:0];
          if (media_sum[64]) res_status <= elss_pkg::ST_OVERFLOW;
        end
      elss_pkg::S_SINIT: begin
        lo <= '0;
        hi <= n_samp;
      end
      elss_pkg::S_SRCH: begin
        mid <= mid_calc;
        if (!(lo < hi) && lo == '0) res_status <= elss_pkg::ST_NONE;
      end
      elss_pkg::S_SCMP:
        if (media < rd_start) hi <= mid;
        else lo <= mid + 1'b1;
      elss_pkg::S_FCMP:
        if (media_diff >= 64'(rd_len)) res_status <= elss_pkg::ST_NONE;
        else res_index <= 12'(lo - 1'b1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (in_xfer && elss_pkg::mode_t'(in_ch.mode) != elss_pkg::MODE_SEEK) begin
      ovalid <= 1'b1;
    end else if (state == elss_pkg::S_RESULT && out_free) begin
      ovalid <= 1'b1;
    end else if (out_ch.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && elss_pkg::mode_t'(in_ch.mode) != elss_pkg::MODE_SEEK) begin
      ostatus <= elss_pkg::ST_OK;
      oindex  <= 12'd0;
    end else if (state == elss_pkg::S_RESULT && out_free) begin
      ostatus <= res_status;
      oindex  <= (res_status == elss_pkg::ST_OK) ? res_index : 12'd0;
    end
  end

  assign out_ch.valid       = ovalid;
  assign out_ch.status      = ostatus;
  assign out_ch.found_index = oindex;

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> state == elss_pkg::S_IDLE)
    else $error("input ready outside idle");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    state == elss_pkg::S_IDLE |-> dcnt == 7'd0 && mcnt == 7'd0)
    else $error("arithmetic unit busy while idle");

  a_search_order: assert property (@(posedge clk) disable iff (rst)
    state == elss_pkg::S_SCMP |-> lo < hi && hi <= n_samp)
    else $error("search bounds broken");

  a_cmp_after_probe: assert property (@(posedge clk) disable iff (rst)
    state == elss_pkg::S_SCMP |-> $past(state) == elss_pkg::S_SRCH)
    else $error("compare without probe read");

endmodule

FILE: sim/edit_list_sample_seek_tb.sv
module edit_list_sample_seek_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int EDITS = 16;
  localparam int SAMPLES = 4096;
  localparam int IDLE_LIMIT = 60000;

  typedef struct {
    elss_pkg::mode_t mode;
    logic [11:0] slot;
    logic [63:0] span;
    logic [63:0] mstart;
    logic [31:0] speed;
    logic [63:0] sstart;
    logic [31:0] slen;
    logic [63:0] qtime;
    logic [31:0] qscale;
  } seek_req_t;

  typedef struct {
    elss_pkg::status_t status;
    logic [11:0] idx;
  } seek_res_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  elss_in_if  in_ch();
  elss_out_if out_ch();

  edit_list_sample_seek u_dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  logic [31:0] timescale_q;
  logic [4:0]  edit_cnt_q;
  logic [12:0] sample_cnt_q;
  logic [63:0] span_mem[EDITS];
  logic [63:0] mstart_mem[EDITS];
  logic [31:0] speed_mem[EDITS];
  logic [63:0] sstart_mem[SAMPLES];
  logic [31:0] slen_mem[SAMPLES];

  seek_res_t pending_q[$];
  seek_res_t head;
  int        error_count;
  int        idle_cycles;
  bit        gaps_on;
  bit        stalls_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic elss_pkg::status_t locate_sample(input logic [63:0] qtime,
                                                      input logic [31:0] qscale,
                                                      output logic [11:0] idx);
    logic [63:0]  elapsed, origin, media, num, den, a, b, r, off;
    logic [63:0]  fac[3];
    logic [127:0] wide;
    logic [31:0]  rate;
    int           n, lo, hi, mid, sel, i;
    bit           hit;
    idx = '0;
    elapsed = qtime;
    origin = '0;
    rate = 32'h1_0000;
    num = 64'd1;
    hit = 1'b0;
    sel = 0;
    if (qscale == 0 || timescale_q == 0) return elss_pkg::ST_ZERO_SCALE;
    n = (edit_cnt_q > EDITS) ? EDITS : edit_cnt_q;
    if (n != 0) begin
      i = 0;
      while (i < n && !hit) begin
        if (elapsed < span_mem[i]) begin
          hit = 1'b1;
          sel = i;
        end else begin
          elapsed -= span_mem[i];
        end
        i++;
      end
      if (!hit || mstart_mem[sel] == '1) return elss_pkg::ST_NONE;
      if (mstart_mem[sel][63]) return elss_pkg::ST_NEG_EDIT;
      if (speed_mem[sel][31]) return elss_pkg::ST_REVERSE;
      rate = speed_mem[sel];
      origin = mstart_mem[sel];
    end
    media = origin;
    if (rate != 0) begin
      den = {32'd0, qscale} << elss_pkg::UNIT_RATE_SHIFT;
      fac[0] = elapsed;
      fac[1] = {32'd0, timescale_q};
      fac[2] = {32'd0, rate};
      for (i = 0; i < 3; i++) begin
        a = fac[i];
        b = den;
        while (b != 0) begin
          r = a % b;
          a = b;
          b = r;
        end
        fac[i] /= a;
        den /= a;
      end
      for (i = 0; i < 3; i++) begin
        wide = {64'd0, num} * {64'd0, fac[i]};
        if (wide[127:64] != 0) return elss_pkg::ST_OVERFLOW;
        num = wide[63:0];
      end
      off = num / den;
      if (off > ~media) return elss_pkg::ST_OVERFLOW;
      media += off;
    end
    n = (sample_cnt_q > SAMPLES) ? SAMPLES : sample_cnt_q;
    lo = 0;
    hi = n;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (media < sstart_mem[mid]) hi = mid;
      else lo = mid + 1;
    end
    if (lo == 0) return elss_pkg::ST_NONE;
    if (media - sstart_mem[lo-1] >= {32'd0, slen_mem[lo-1]}) return elss_pkg::ST_NONE;
    idx = 12'(lo - 1);
    return elss_pkg::ST_OK;
  endfunction

  function automatic seek_res_t apply_request(input seek_req_t rq);
    seek_res_t res;
    res.status = elss_pkg::ST_OK;
    res.idx = '0;
    case (rq.mode)
      elss_pkg::MODE_EDIT: begin
        if (rq.slot < EDITS) begin
          span_mem[rq.slot] = rq.span;
          mstart_mem[rq.slot] = rq.mstart;
          speed_mem[rq.slot] = rq.speed;
        end
      end
      elss_pkg::MODE_SAMPLE: begin
        sstart_mem[rq.slot] = rq.sstart;
        slen_mem[rq.slot] = rq.slen;
      end
      elss_pkg::MODE_SEEK: res.status = locate_sample(rq.qtime, rq.qscale, res.idx);
      default: ;
    endcase
    return res;
  endfunction

  task automatic send_request(input seek_req_t rq);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.mode          <= rq.mode;
    in_ch.entry_index   <= rq.slot;
    in_ch.edit_span     <= rq.span;
    in_ch.edit_start    <= rq.mstart;
    in_ch.edit_speed    <= rq.speed;
    in_ch.sample_start  <= rq.sstart;
    in_ch.sample_length <= rq.slen;
    in_ch.query_time    <= rq.qtime;
    in_ch.query_scale   <= rq.qscale;
    do @(posedge clk); while (!in_ch.ready);
    pending_q = {pending_q, apply_request(rq)};
  endtask

  function automatic seek_req_t noise_req(input elss_pkg::mode_t m);
    seek_req_t rq;
    rq.mode = m;
    rq.slot = 12'($urandom);
    rq.span = rnd64();
    rq.mstart = rnd64();
    rq.speed = $urandom;
    rq.sstart = rnd64();
    rq.slen = $urandom;
    rq.qtime = rnd64();
    rq.qscale = $urandom;
    return rq;
  endfunction

  task automatic put_edit(input int slot, input logic [63:0] span,
                          input logic [63:0] mstart, input logic [31:0] speed);
    seek_req_t rq;
    rq = noise_req(elss_pkg::MODE_EDIT);
    rq.slot = 12'(slot);
    rq.span = span;
    rq.mstart = mstart;
    rq.speed = speed;
    send_request(rq);
  endtask

  task automatic put_sample(input int slot, input logic [63:0] sstart,
                            input logic [31:0] slen);
    seek_req_t rq;
    rq = noise_req(elss_pkg::MODE_SAMPLE);
    rq.slot = 12'(slot);
    rq.sstart = sstart;
    rq.slen = slen;
    send_request(rq);
  endtask

  task automatic seek(input logic [63:0] qtime, input logic [31:0] qscale);
    seek_req_t rq;
    rq = noise_req(elss_pkg::MODE_SEEK);
    rq.qtime = qtime;
    rq.qscale = qscale;
    send_request(rq);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(input elss_pkg::reg_idx_t ri, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 4'(ri) << 2;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (ri)
      elss_pkg::REG_TIMESCALE:    timescale_q = value;
      elss_pkg::REG_EDIT_COUNT:   edit_cnt_q = value[4:0];
      elss_pkg::REG_SAMPLE_COUNT: sample_cnt_q = value[12:0];
      default: ;
    endcase
  endtask

  task automatic test_directed();
    int i;
    seek(rnd64(), 32'd1000);
    send_request(noise_req(elss_pkg::MODE_NONE));
    drain();
    reg_write(elss_pkg::REG_TIMESCALE, 32'd1000);
    put_edit(0, 64'd100, '1, 32'h1_0000);
    put_edit(1, 64'd1000, 64'd0, 32'h1_0000);
    put_edit(2, 64'd50, -64'sd5, 32'h1_0000);
    put_edit(3, 64'd50, 64'd10, 32'hFFFF_0000);
    put_edit(4, 64'd50, 64'd300, 32'd0);
    put_edit(5, 64'd50, 64'd0, 32'h7FFF_FFFF);
    put_edit(6, 64'h4000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 32'h1_0000);
    for (i = 7; i < EDITS; i++) put_edit(i, 64'($urandom_range(1, 5000)), 64'd0, 32'h1_0000);
    put_edit(4095, '1, '1, '1);
    for (i = 0; i < 64; i++) put_sample(i, 64'(i * 100), 32'd100);
    drain();
    reg_write(elss_pkg::REG_EDIT_COUNT, 32'd16);
    reg_write(elss_pkg::REG_SAMPLE_COUNT, 32'd64);
    seek(64'd50, 32'd1000);
    seek(64'd600, 32'd1000);
    seek(64'd1110, 32'd1000);
    seek(64'd1160, 32'd1000);
    seek(64'd1210, 32'd1000);
    seek(64'd1260, 32'd1000);
    seek(64'd1299, 32'd1000);
    seek(64'd1310, 32'd1);
    seek('1, 32'd1000);
    seek(64'd600, 32'd0);
    seek(64'd600, 32'hFFFF_FFFF);
    drain();
    reg_write(elss_pkg::REG_TIMESCALE, 32'hFFFF_FFFF);
    seek(64'd1299, 32'd1);
    drain();
    reg_write(elss_pkg::REG_TIMESCALE, 32'd0);
    seek(64'd600, 32'd1000);
    drain();
    reg_write(elss_pkg::REG_TIMESCALE, 32'd1000);
    reg_write(elss_pkg::REG_EDIT_COUNT, 32'd0);
    seek(64'd6350, 32'd1000);
    put_sample(2, '1, 32'hFFFF_FFFF);
    seek(64'd250, 32'd1000);
    drain();
    reg_write(elss_pkg::REG_EDIT_COUNT, 32'd31);
    seek(64'd600, 32'd1000);
    drain();
  endtask

  task automatic test_round(input int n_items);
    int          i, n_samp, n_edit, kind;
    logic [63:0] cursor, total;
    logic [31:0] ts, qs;
    seek_req_t   rq;
    n_samp = $urandom_range(1, 64);
    n_edit = $urandom_range(1, EDITS);
    cursor = 64'($urandom_range(0, 1000));
    for (i = 0; i < n_samp; i++) begin
      put_sample(i, cursor, 32'($urandom_range(1, 400)));
      cursor += 64'($urandom_range(0, 500));
    end
    total = '0;
    for (i = 0; i < n_edit; i++) begin
      kind = $urandom_range(0, 19);
      rq.span = 64'($urandom_range(1, 5000));
      total += rq.span;
      rq.mstart = 64'($urandom_range(0, 32'(cursor)));
      rq.speed = (kind < 12) ? 32'h1_0000 : (kind < 14) ? 32'h8000 :
                 (kind < 16) ? 32'h2_0000 : (kind < 17) ? 32'd0 : $urandom;
      if (kind == 18) rq.mstart = '1;
      if (kind == 19) rq.mstart = rnd64();
      put_edit(i, rq.span, rq.mstart, rq.speed);
    end
    drain();
    ts = ($urandom_range(0, 3) == 0) ? $urandom : 32'd1000;
    qs = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(1, 2000)) : ts;
    reg_write(elss_pkg::REG_TIMESCALE, ts);
    reg_write(elss_pkg::REG_EDIT_COUNT, 32'(n_edit));
    reg_write(elss_pkg::REG_SAMPLE_COUNT, 32'(n_samp));
    for (i = 0; i < n_items; i++) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        seek(rnd64() % (total + 16), ($urandom_range(0, 15) == 0) ? $urandom : qs);
      end else if (kind == 7) begin
        send_request(noise_req(elss_pkg::MODE_NONE));
      end else if (kind == 8) begin
        rq = noise_req(elss_pkg::MODE_SAMPLE);
        rq.slot = 12'($urandom_range(0, n_samp - 1));
        send_request(rq);
      end else begin
        send_request(noise_req(elss_pkg::MODE_EDIT));
      end
    end
    drain();
  endtask

  task automatic test_random();
    int r;
    for (r = 0; r < 9; r++) test_round(14);
  endtask

  task automatic test_full_table();
    int lo, hi, mid;
    lo = 0;
    hi = SAMPLES;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      put_sample(mid, 64'(mid), 32'd100);
      lo = mid + 1;
    end
    drain();
    reg_write(elss_pkg::REG_TIMESCALE, 32'd1);
    reg_write(elss_pkg::REG_EDIT_COUNT, 32'd0);
    reg_write(elss_pkg::REG_SAMPLE_COUNT, 32'h1FFF);
    seek('1, 32'd1);
    seek(64'(SAMPLES + 49), 32'd1);
    seek(64'(SAMPLES + 200), 32'd1);
    drain();
    reg_write(elss_pkg::REG_SAMPLE_COUNT, 32'd4096);
    seek(64'(SAMPLES + 10), 32'd1);
    drain();
  endtask

  task automatic test_back_to_back();
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    test_round(30);
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (stalls_on && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_q.size() == 0) begin
        $error("result with nothing pending: status=%0d found_index=%0d",
               out_ch.status, out_ch.found_index);
        error_count++;
      end else begin
        head = pending_q.pop_front();
        if (out_ch.status !== head.status) begin
          $error("status: expected %0d, got %0d", head.status, out_ch.status);
          error_count++;
        end
        if (out_ch.found_index !== head.idx) begin
          $error("found_index: expected %0d, got %0d", head.idx, out_ch.found_index);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    error_count = 0;
    idle_cycles = 0;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    timescale_q = 32'd1;
    edit_cnt_q = '0;
    sample_cnt_q = '0;
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.mode <= elss_pkg::MODE_EDIT;
    in_ch.entry_index <= '0;
    in_ch.edit_span <= '0;
    in_ch.edit_start <= '0;
    in_ch.edit_speed <= '0;
    in_ch.sample_start <= '0;
    in_ch.sample_length <= '0;
    in_ch.query_time <= '0;
    in_ch.query_scale <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    test_full_table();
    test_back_to_back();
    drain();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: edit_list_sample_seek.f
hw/rtl/elss_pkg.sv
hw/rtl/elss_if.sv
hw/rtl/edit_list_sample_seek.sv
sim/edit_list_sample_seek_tb.sv
